/* rtl/core/mfasu_pkg.sv */
`timescale 1ns / 1ps
package mfasu_pkg;
    localparam logic [10:0] MF_NAN  = 11'h7ff;
    localparam logic [10:0] MF_PINF = 11'h3c0;
    localparam logic [10:0] MF_NINF = 11'h7c0;
    localparam logic [10:0] MF_SIGN = 11'h400;
    localparam int          MF_BIAS = 7;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_NEG = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_NORM = 4'b0010,
        ST_PACK = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    typedef struct packed {
        logic        start;
        logic [20:0] mag;
        logic signed [6:0] exp;
    } t_norm_req;

    function automatic logic is_nan(input logic [10:0] v);
        return (v[9:6] == 4'hf) && (v[5:0] != 6'd0);
    endfunction

    function automatic logic is_inf(input logic [10:0] v);
        return (v == MF_PINF) || (v == MF_NINF);
    endfunction

    function automatic logic is_zero(input logic [10:0] v);
        return v[9:0] == 10'd0;
    endfunction

    function automatic logic [6:0] sig_of(input logic [10:0] v);
        return (v[9:6] == 4'd0) ? {1'b0, v[5:0]} : {1'b1, v[5:0]};
    endfunction

    function automatic logic signed [6:0] exp_of(input logic [10:0] v);
        return (v[9:6] == 4'd0) ? -7'sd6 : $signed({3'b000, v[9:6]}) - 7'sd7;
    endfunction
endpackage

/* rtl/core/mfasu_norm.sv */
`timescale 1ns / 1ps
module mfasu_norm
    import mfasu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_norm_req         i_req,
    output logic              o_done,
    output logic [20:0]       o_mag,
    output logic signed [6:0] o_exp
);
    logic [20:0]       r_mag, n_mag;
    logic signed [6:0] r_exp, n_exp;
    logic              r_busy, n_busy;

    always_comb begin
        n_mag  = r_mag;
        n_exp  = r_exp;
        n_busy = r_busy;
        if (i_req.start) begin
            n_mag  = i_req.mag;
            n_exp  = i_req.exp;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_mag[20:7] != 14'd0) begin
                n_mag = {1'b0, r_mag[20:1]};
                n_exp = r_exp + 7'sd1;
            end else begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_mag <= n_mag;
        r_exp <= n_exp;
    end

    assign o_done = r_busy && !i_req.start && (r_mag[20:7] == 14'd0);
    assign o_mag  = r_mag;
    assign o_exp  = r_exp;
endmodule

/* rtl/core/minifloat_add_sub_mul_unit_core.sv */
`timescale 1ns / 1ps
// Special cases and negate go from the normalize state straight to done; add, subtract and
// multiply also pass the pack state, where up to 14 right shifts normalize a 21-bit value.
// The input stalls while busy, also while output stalls hold the result in the done state.
// Reset: synchronous active-low i_rst_n clears the sequencer and output valid.
module minifloat_add_sub_mul_unit_core
    import mfasu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [10:0] i_operand_a,
    input  logic [10:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [10:0] o_result_value
);
    t_state r_state, n_state;
    logic [10:0] r_a, r_b, r_res, n_res;
    logic [1:0]  r_op;
    logic        r_sign, n_sign;
    logic [20:0] n_mag;
    logic signed [6:0] n_exp;
    t_norm_req   w_req;
    logic        w_done;
    logic [20:0] w_mag;
    logic signed [6:0] w_exp;

    logic [10:0] w_b;
    logic        w_special;
    logic [10:0] w_sres;
    logic signed [6:0] w_ea, w_eb, w_emin;
    logic signed [21:0] w_va, w_vb, w_sum;
    logic [13:0] w_prod;

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_DONE);
    assign o_result_value = r_res;
    assign w_b = (r_op == OP_SUB) ? (r_b ^ MF_SIGN) : r_b;

    always_comb begin
        w_special = 1'b1;
        w_sres    = 11'd0;
        w_ea = exp_of(r_a);
        w_eb = exp_of(w_b);
        w_emin = (w_ea < w_eb) ? w_ea : w_eb;
        w_va = $signed({15'd0, sig_of(r_a)} << (w_ea - w_emin));
        w_vb = $signed({15'd0, sig_of(w_b)} << (w_eb - w_emin));
        if (r_a[10]) w_va = -w_va;
        if (w_b[10]) w_vb = -w_vb;
        w_sum  = w_va + w_vb;
        w_prod = {7'd0, sig_of(r_a)} * {7'd0, sig_of(w_b)};
        n_sign = 1'b0;
        n_mag  = 21'd0;
        n_exp  = 7'sd0;
        case (r_op)
            OP_NEG: begin
                w_sres = is_nan(r_a) ? MF_NAN : (r_a ^ MF_SIGN);
            end
            OP_MUL: begin
                n_sign = r_a[10] ^ w_b[10];
                if (is_nan(r_a) || is_nan(w_b)) w_sres = MF_NAN;
                else if ((is_inf(r_a) && is_zero(w_b)) || (is_inf(w_b) && is_zero(r_a)))
                    w_sres = MF_NAN;
                else if (is_inf(r_a) || is_inf(w_b)) w_sres = MF_PINF | {n_sign, 10'd0};
                else if (is_zero(r_a) || is_zero(w_b)) w_sres = {n_sign, 10'd0};
                else begin
                    w_special = 1'b0;
                    n_mag = {7'd0, w_prod};
                    n_exp = w_ea + w_eb - 7'sd12;
                end
            end
            default: begin
                if ((r_a == MF_PINF && w_b == MF_NINF) || (r_a == MF_NINF && w_b == MF_PINF))
                    w_sres = MF_NAN;
                else if (is_nan(r_a) || is_nan(w_b)) w_sres = MF_NAN;
                else if (is_inf(r_a) && is_inf(w_b)) w_sres = MF_PINF | (r_a & w_b & MF_SIGN);
                else if (r_a == (w_b ^ MF_SIGN)) w_sres = 11'd0;
                else if (r_a == MF_PINF || w_b == MF_PINF) w_sres = MF_PINF;
                else if (r_a == MF_NINF || w_b == MF_NINF) w_sres = MF_NINF;
                else if (is_zero(r_a) && is_zero(w_b)) w_sres = r_a & w_b & MF_SIGN;
                else if (is_zero(r_a)) w_sres = w_b;
                else if (is_zero(w_b)) w_sres = r_a;
                else begin
                    w_special = 1'b0;
                    n_sign = w_sum[21];
                    n_mag  = w_sum[21] ? 21'(-w_sum) : 21'(w_sum);
                    n_exp  = w_emin - 7'sd6;
                end
            end
        endcase
    end

    assign w_req.start = (r_state == ST_NORM) && !w_special;
    assign w_req.mag   = n_mag;
    assign w_req.exp   = n_exp;

    mfasu_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_done),
        .o_mag   (w_mag),
        .o_exp   (w_exp)
    );

    logic [2:0] w_p;
    logic signed [7:0] w_bex;
    logic signed [7:0] w_sh;
    logic [6:0] w_m7;

    always_comb begin
        w_p = 3'd0;
        for (int k = 1; k < 7; k++) begin
            if (w_mag[k]) w_p = 3'(k);
        end
        w_m7  = w_mag[6:0];
        w_bex = 8'(w_exp) + 8'(w_p) + 8'sd7;
        w_sh  = 8'(w_exp) + 8'sd12;
        if (w_mag == 21'd0) n_res = {r_sign, 10'd0};
        else if (w_bex >= 8'sd15) n_res = {r_sign, 10'h3c0};
        else if (w_bex >= 8'sd1) n_res = {r_sign, w_bex[3:0], 6'(w_m7 << (3'd6 - w_p))};
        else if (w_sh >= 8'sd0)
            n_res = {r_sign, 4'd0, 6'(w_m7 << ((w_sh > 8'sd6) ? 3'd6 : w_sh[2:0]))};
        else if (w_sh <= -8'sd7) n_res = {r_sign, 10'd0};
        else n_res = {r_sign, 4'd0, 6'(w_m7 >> 3'(-w_sh))};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_NORM;
            ST_NORM: n_state = w_special ? ST_DONE : ST_PACK;
            ST_PACK: if (w_done) n_state = ST_DONE;
            ST_DONE: if (!i_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (r_state == ST_IDLE && i_valid) begin
            r_op <= i_req_type;
            r_a  <= i_operand_a;
            r_b  <= i_operand_b;
        end
        if (r_state == ST_NORM) begin
            r_sign <= n_sign;
            if (w_special) r_res <= w_sres;
        end
        if (r_state == ST_PACK && w_done) r_res <= n_res;
    end
endmodule
